/* rtl/imod_pkg.sv */
// Package: shared types and constants for the interval overlap depth block.
`timescale 1ns / 1ps
package imod_pkg;

    localparam int MAX_INTERVALS_DEF = 256;
    localparam int DEPTH_W = 9;
    localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;

    typedef enum logic [1:0] {
        OP_ADD         = 2'd0,
        OP_ADD_COMPUTE = 2'd1,
        OP_COMPUTE     = 2'd2,
        OP_NONE        = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] left_coord;
        logic signed [31:0] right_coord;
    } t_in_item;

    typedef struct packed {
        logic [DEPTH_W-1:0] max_depth;
        logic               overflow;
    } t_out_item;

endpackage

/* rtl/imod_store.sv */
// Endpoint store: two synchronous RAMs, 1 write port, read ports: 2 start, 1 end.
`timescale 1ns / 1ps
module imod_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wstart,
    input  logic [31:0]   i_wend,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [31:0]   o_start_a,
    output logic [31:0]   o_start_b,
    output logic [31:0]   o_end_b
);
    logic [31:0] r_start_mem [DEPTH];
    logic [31:0] r_end_mem   [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_start_mem[i_waddr] <= i_wstart;
            r_end_mem[i_waddr]   <= i_wend;
        end
    end

    // registered reads: pivot start on port a, scanned entry on port b
    always_ff @(posedge i_clk) begin
        o_start_a <= r_start_mem[i_raddr_a];
        o_start_b <= r_start_mem[i_raddr_b];
        o_end_b   <= r_end_mem[i_raddr_b];
    end
endmodule

/* rtl/interval_max_overlap_depth.sv */
// Top level: interval load, sweep of the stored endpoints and result register.
//
// Usage: items arrive on i_in_* (valid/ready). Opcode add stores one interval
// (dropped and flagged when the store is full); add-then-compute and compute
// return one result on o_out_*: the largest overlap depth and the drop flag,
// after which the store is empty. Opcode three is ignored.
// Operation: adds are taken in the idle state. A compute with N stored intervals
// walks every pivot against every entry through the store's read ports (per pivot
// a pivot read, an issue per entry, one drain and one compare step), or goes
// straight to the result on an empty store; the walk is set by the single scanning
// read port. The result waits in an output register while the receiver stalls,
// and no new item is taken until the cycle after it is transferred.
// Reset (synchronous, active low) empties the store and clears the drop flag;
// stored data is not cleared, entries are only read below the fill count.
`timescale 1ns / 1ps
module interval_max_overlap_depth #(
    parameter int MAX_INTERVALS = imod_pkg::MAX_INTERVALS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  imod_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output imod_pkg::t_out_item  o_out_data
);
    import imod_pkg::*;

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int RW = CW + 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PIV  = 4'b0010,
        S_SCAN = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic r_drop, n_drop;
    logic [AW-1:0] r_piv, n_piv;
    logic [CW-1:0] r_scan, n_scan;       // entries issued this pivot
    logic r_vld, n_vld;                  // store data valid this cycle
    logic signed [RW-1:0] r_run, n_run;
    logic [CW-1:0] r_best, n_best;
    t_out_item r_out, n_out;

    logic we;
    logic [AW-1:0] raddr_b;
    logic [31:0] piv_s, sb, eb;
    logic acc;
    t_opcode op;
    logic last_piv;

    assign op = t_opcode'(i_in_data.opcode);
    assign o_in_ready = (r_state == S_IDLE);
    assign acc = i_in_valid && o_in_ready;
    assign we = acc && (op == OP_ADD || op == OP_ADD_COMPUTE) &&
                (r_count < CW'(MAX_INTERVALS));
    assign raddr_b = r_scan[AW-1:0];
    assign last_piv = ({1'b0, r_piv} == {1'b0, AW'(r_count - CW'(1))}) ||
                      (CW'(r_piv) + CW'(1) >= r_count);

    imod_store #(.DEPTH(MAX_INTERVALS), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_count[AW-1:0]),
        .i_wstart  ({~i_in_data.left_coord[31], i_in_data.left_coord[30:0]}),
        .i_wend    ({~i_in_data.right_coord[31], i_in_data.right_coord[30:0]}),
        .i_raddr_a (r_piv),
        .i_raddr_b (raddr_b),
        .o_start_a (piv_s),
        .o_start_b (sb),
        .o_end_b   (eb)
    );

    // control: load, then pivot loop with an inner scan, then result hold
    always_comb begin
        logic signed [RW-1:0] run_new;
        logic [CW-1:0] sat;
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        n_piv   = r_piv;
        n_scan  = r_scan;
        n_vld   = 1'b0;
        n_run   = r_run;
        n_best  = r_best;
        n_out   = r_out;
        run_new = r_run + RW'(sb <= piv_s) - RW'(eb < piv_s);
        sat = r_best;
        case (r_state)
            S_IDLE: begin
                if (acc && op != OP_NONE) begin
                    if (op != OP_COMPUTE) begin
                        if (we) n_count = r_count + CW'(1);
                        else    n_drop  = 1'b1;
                    end
                    if (op != OP_ADD) begin
                        n_piv  = '0;
                        n_best = '0;
                        if (n_count == '0) n_state = S_OUT;
                        else               n_state = S_PIV;
                    end
                end
            end
            S_PIV: begin
                // pivot start read issues this cycle; scan starts next
                n_scan  = '0;
                n_run   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_vld) n_run = run_new;
                if (r_scan < r_count) begin
                    n_scan = r_scan + CW'(1);
                    n_vld  = 1'b1;
                end else if (!r_vld) begin
                    if (r_run > $signed({2'b00, r_best})) n_best = r_run[CW-1:0];
                    if (last_piv) begin
                        n_state = S_OUT;
                    end else begin
                        n_piv   = r_piv + AW'(1);
                        n_state = S_PIV;
                    end
                end
            end
            S_OUT: begin
                if (r_vld) begin
                    n_vld = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // result capture on the way into S_OUT
        if (n_state == S_OUT && r_state != S_OUT) begin
            sat = n_best;
            if (CW > DEPTH_W && sat > CW'(DEPTH_SAT)) n_out.max_depth = DEPTH_SAT;
            else n_out.max_depth = DEPTH_W'(sat);
            n_out.overflow = n_drop;
            n_count = '0;
            n_drop  = 1'b0;
        end
        if (r_state == S_OUT && i_out_ready) n_state = S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_piv  <= n_piv;
        r_scan <= n_scan;
        r_run  <= n_run;
        r_best <= n_best;
        r_out  <= n_out;
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    // no input taken while a result is held
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input ready during result hold");
    // fill count never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_INTERVALS)) else $error("fill count over capacity");
    // store is empty after a result transfer
    a_empty_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (r_count == '0 && !r_drop))
        else $error("store not emptied after result");
    // result depth bounded by the store capacity
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_data.max_depth) <= 32'(MAX_INTERVALS)))
        else $error("depth above capacity");
endmodule
